[rtl/core/spd_pkg.sv]
// Package: shared constants, types and functions of the sensor packet deframer.
`timescale 1ns / 1ps
package spd_pkg;
  localparam int PACKET_BYTES_DEF = 33;
  localparam logic [7:0] SYNC0 = 8'h55;
  localparam logic [7:0] SYNC1 = 8'hAA;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0] VERSION_RESET = 8'd1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [2:0] OUT_NONE = 3'd0;
  localparam logic [2:0] OUT_VALID = 3'd1;
  localparam logic [2:0] OUT_VERSION = 3'd2;
  localparam logic [2:0] OUT_CRC = 3'd3;
  localparam logic [2:0] OUT_SKIP = 3'd4;

  typedef struct packed {
    logic [2:0] outcome;
    logic [31:0] pkt_counter;
    logic [63:0] stamp_usec;
    logic [31:0] interval_us;
    logic signed [15:0] left_dx;
    logic signed [15:0] left_dy;
    logic [7:0] left_quality;
    logic [7:0] left_status;
    logic signed [15:0] right_dx;
    logic signed [15:0] right_dy;
    logic [7:0] right_quality;
    logic [7:0] right_status;
  } result_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction
endpackage

[rtl/core/spd_if.sv]
// Interfaces: valid/ready channels for input bytes and decoded results.
`timescale 1ns / 1ps
interface spd_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [7:0] data_byte;
  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

interface spd_out_if;
  logic valid;
  logic ready;
  spd_pkg::result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/spd_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
`timescale 1ns / 1ps
module spd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 33
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/spd_judge.sv]
// Sequencer: stores bytes in the ring, scans a full window, checks and decodes it.
`timescale 1ns / 1ps
module spd_judge #(
  parameter int PACKET_BYTES = spd_pkg::PACKET_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] packet_version,
  spd_in_if.sink  in_ch,
  spd_out_if.source out_ch
);
  localparam int AW = $clog2(PACKET_BYTES);
  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int CRC_SPAN = PACKET_BYTES - 2;
  localparam int FIELD_BITS = $bits(spd_pkg::result_t) - 3;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;
  state_t state;

  logic [AW-1:0] head;       // slot of the oldest byte
  logic [CW-1:0] fill_count;
  logic [CW-1:0] consume_count;
  logic [CW-1:0] rd_idx;     // window offset being read
  logic [CW-1:0] got_idx;    // window offset of rdata
  logic          got_valid;
  logic [15:0]   crc;
  logic [15:0]   crc_rx;
  logic          bad_hdr, bad_ver;
  spd_pkg::result_t res;
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] raddr;

  function automatic logic [AW-1:0] wrap(input logic [CW:0] v);
    logic [CW:0] r;
    r = (v >= (CW+1)'(PACKET_BYTES)) ? v - (CW+1)'(PACKET_BYTES) : v;
    return r[AW-1:0];
  endfunction

  assign we = in_ch.valid && in_ch.ready && (in_ch.operation == spd_pkg::OP_PUSH);
  assign raddr = wrap({1'b0, head} + (CW+1)'(rd_idx));
  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;

  spd_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(head), .wdata(in_ch.data_byte),
    .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      fill_count <= '0;
      consume_count <= '0;
      out_ch.valid <= 1'b0;
      got_valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            res <= '0;
            if (in_ch.operation == spd_pkg::OP_CLEAR) begin
              fill_count <= '0;
              consume_count <= '0;
              out_ch.valid <= 1'b1;
            end else begin
              // new byte overwrites the oldest slot; head then points at new oldest
              head <= wrap({1'b0, head} + (CW+1)'(1));
              if (fill_count < CW'(PACKET_BYTES) - CW'(1)) begin
                fill_count <= fill_count + CW'(1);
                out_ch.valid <= 1'b1;
              end else begin
                fill_count <= CW'(PACKET_BYTES);
                if (consume_count != '0) begin
                  consume_count <= consume_count - CW'(1);
                  out_ch.valid <= 1'b1;
                end else begin
                  state <= S_SCAN;
                  rd_idx <= '0;
                  got_valid <= 1'b0;
                  crc <= spd_pkg::CRC_INIT;
                  bad_hdr <= 1'b0;
                  bad_ver <= 1'b0;
                end
              end
            end
          end
        end
        S_SCAN: begin
          if (rd_idx < CW'(PACKET_BYTES)) rd_idx <= rd_idx + CW'(1);
          got_idx <= rd_idx;
          got_valid <= rd_idx < CW'(PACKET_BYTES);
          if (got_valid) begin
            if (got_idx < CW'(CRC_SPAN)) crc <= spd_pkg::crc_byte(crc, rdata);
            if (got_idx == CW'(0) && rdata != spd_pkg::SYNC0) bad_hdr <= 1'b1;
            if (got_idx == CW'(1) && rdata != spd_pkg::SYNC1) bad_hdr <= 1'b1;
            if (got_idx == CW'(2) && rdata != packet_version) bad_ver <= 1'b1;
            if (got_idx == CW'(CRC_SPAN)) crc_rx[7:0] <= rdata;
            if (got_idx == CW'(CRC_SPAN + 1)) crc_rx[15:8] <= rdata;
            case (got_idx)
              CW'(3):  res.pkt_counter[7:0]   <= rdata;
              CW'(4):  res.pkt_counter[15:8]  <= rdata;
              CW'(5):  res.pkt_counter[23:16] <= rdata;
              CW'(6):  res.pkt_counter[31:24] <= rdata;
              CW'(7):  res.stamp_usec[7:0]   <= rdata;
              CW'(8):  res.stamp_usec[15:8]  <= rdata;
              CW'(9):  res.stamp_usec[23:16] <= rdata;
              CW'(10): res.stamp_usec[31:24] <= rdata;
              CW'(11): res.stamp_usec[39:32] <= rdata;
              CW'(12): res.stamp_usec[47:40] <= rdata;
              CW'(13): res.stamp_usec[55:48] <= rdata;
              CW'(14): res.stamp_usec[63:56] <= rdata;
              CW'(15): res.interval_us[7:0]   <= rdata;
              CW'(16): res.interval_us[15:8]  <= rdata;
              CW'(17): res.interval_us[23:16] <= rdata;
              CW'(18): res.interval_us[31:24] <= rdata;
              CW'(19): res.left_dx[7:0]  <= rdata;
              CW'(20): res.left_dx[15:8] <= rdata;
              CW'(21): res.left_dy[7:0]  <= rdata;
              CW'(22): res.left_dy[15:8] <= rdata;
              CW'(23): res.left_quality  <= rdata;
              CW'(24): res.left_status   <= rdata;
              CW'(25): res.right_dx[7:0]  <= rdata;
              CW'(26): res.right_dx[15:8] <= rdata;
              CW'(27): res.right_dy[7:0]  <= rdata;
              CW'(28): res.right_dy[15:8] <= rdata;
              CW'(29): res.right_quality <= rdata;
              CW'(30): res.right_status  <= rdata;
              default: ;
            endcase
            if (got_idx == CW'(PACKET_BYTES - 1)) state <= S_DONE;
          end
        end
        S_DONE: begin
          // judge in priority order: header, version, crc
          if (bad_hdr) begin
            res <= {spd_pkg::OUT_SKIP, FIELD_BITS'(0)};
          end else if (bad_ver) begin
            res <= {spd_pkg::OUT_VERSION, FIELD_BITS'(0)};
          end else if (crc != crc_rx) begin
            res <= {spd_pkg::OUT_CRC, FIELD_BITS'(0)};
          end else begin
            res.outcome <= spd_pkg::OUT_VALID;
            consume_count <= CW'(PACKET_BYTES - 1);
          end
          out_ch.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.payload = res;
endmodule

[rtl/core/sensor_packet_deframer_crc16_top.sv]
// Top level: sensor packet deframer with CRC-16/CCITT-FALSE check.
//
//  channel  | dir | transaction payload
//  ---------+-----+-------------------------------------------------
//  in_ch    | in  | operation (push/clear), data_byte
//  out_ch   | out | outcome and eleven decoded packet fields
//  cfg      | in  | cfg_we / cfg_data -> packet_version
//
// Clear items and bytes that judge nothing give a registered result straight from idle.
// A judged window is scanned: one RAM read per byte feeds the byte-serial CRC
// and decode, then a judge state sets the outcome and the result is registered.
// Reset (rst, synchronous) empties the window and sets packet_version to 1.
// The block takes one transaction at a time; a held result stalls input.
`timescale 1ns / 1ps
module sensor_packet_deframer_crc16_top #(
  parameter int PACKET_BYTES = spd_pkg::PACKET_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [7:0] cfg_data,
  spd_in_if.sink  in_ch,
  spd_out_if.source out_ch
);
  logic [7:0] packet_version;

  // Hold the version register; software must write it only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) packet_version <= spd_pkg::VERSION_RESET;
    else if (cfg_we) packet_version <= cfg_data;
  end

  spd_judge #(.PACKET_BYTES(PACKET_BYTES)) u_judge (
    .clk(clk), .rst(rst), .packet_version(packet_version),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  // Never accept input while a result waits.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> !(in_ch.valid && in_ch.ready) || !out_ch.valid)
    else $error("input accepted while result pending");

  // Decoded fields stay zero unless the packet was valid (checked on pkt_counter and stamp_usec).
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.payload.outcome != spd_pkg::OUT_VALID
      |-> out_ch.payload.pkt_counter == '0 && out_ch.payload.stamp_usec == '0)
    else $error("fields nonzero on invalid outcome");

  // Outcome code stays in range.
  a_outcome_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.payload.outcome <= spd_pkg::OUT_SKIP)
    else $error("outcome code out of range");
endmodule

[bench/sensor_packet_deframer_crc16_top_test.sv]
// Testbench for the sensor packet deframer: directed and random byte streams checked against a predictor.
`timescale 1ns / 1ps
module sensor_packet_deframer_crc16_top_test;
  localparam int NBYTES = spd_pkg::PACKET_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_data;

  spd_in_if in_ch ();
  spd_out_if out_ch ();

  sensor_packet_deframer_crc16_top u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Clock: 2 ns period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Predictor state: a private copy of the window and counters.
  logic [7:0] win_bytes [NBYTES];
  int fill_level;
  int skip_left;
  logic [7:0] version_reg;

  spd_pkg::result_t expected_results[$];
  int error_count;
  int idle_cycles;
  bit src_idle_en;
  bit snk_idle_en;
  bit long_hold;

  function automatic logic [15:0] crc16_ccitt(input logic [7:0] w [NBYTES], input int n);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i < n; i++) begin
      c = c ^ {w[i], 8'h00};
      for (int b = 0; b < 8; b++) begin
        c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      end
    end
    return c;
  endfunction

  function automatic logic [63:0] le_field(input logic [7:0] w [NBYTES], input int first,
                                           input int n);
    logic [63:0] v;
    v = '0;
    for (int i = first + n - 1; i >= first; i--) begin
      v = (v << 8) | 64'(w[i]);
    end
    return v;
  endfunction

  // Advance the predictor by one transaction and return the expected result.
  function automatic spd_pkg::result_t deframe_byte(input logic op, input logic [7:0] data);
    spd_pkg::result_t r;
    r = '0;
    r.outcome = spd_pkg::OUT_NONE;
    if (op == spd_pkg::OP_CLEAR) begin
      fill_level = 0;
      skip_left = 0;
      return r;
    end
    for (int i = 0; i < NBYTES - 1; i++) win_bytes[i] = win_bytes[i + 1];
    win_bytes[NBYTES - 1] = data;
    if (fill_level < NBYTES) fill_level++;
    if (fill_level < NBYTES) return r;
    if (skip_left > 0) begin
      skip_left--;
      return r;
    end
    if (win_bytes[0] != spd_pkg::SYNC0 || win_bytes[1] != spd_pkg::SYNC1) begin
      r.outcome = spd_pkg::OUT_SKIP;
      return r;
    end
    if (win_bytes[2] != version_reg) begin
      r.outcome = spd_pkg::OUT_VERSION;
      return r;
    end
    if (crc16_ccitt(win_bytes, NBYTES - 2) != 16'(le_field(win_bytes, NBYTES - 2, 2))) begin
      r.outcome = spd_pkg::OUT_CRC;
      return r;
    end
    r.outcome = spd_pkg::OUT_VALID;
    r.pkt_counter = 32'(le_field(win_bytes, 3, 4));
    r.stamp_usec = le_field(win_bytes, 7, 8);
    r.interval_us = 32'(le_field(win_bytes, 15, 4));
    r.left_dx = 16'(le_field(win_bytes, 19, 2));
    r.left_dy = 16'(le_field(win_bytes, 21, 2));
    r.left_quality = win_bytes[23];
    r.left_status = win_bytes[24];
    r.right_dx = 16'(le_field(win_bytes, 25, 2));
    r.right_dy = 16'(le_field(win_bytes, 27, 2));
    r.right_quality = win_bytes[29];
    r.right_status = win_bytes[30];
    skip_left = NBYTES - 1;
    return r;
  endfunction

  // Send one transaction; predict at acceptance, with random idle bursts before it.
  task automatic send_byte(input logic op, input logic [7:0] data);
    spd_pkg::result_t exp_item;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.data_byte = data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    exp_item = deframe_byte(op, data);
    expected_results.insert(expected_results.size(), exp_item);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] data);
    send_byte(spd_pkg::OP_PUSH, data);
  endtask

  // Build a packet with the given version; corrupt the CRC when asked.
  task automatic send_packet(input logic [7:0] ver, input bit bad_crc, input bit extremes,
                             input bit all_ones);
    logic [7:0] pkt [NBYTES];
    logic [15:0] c;
    pkt[0] = spd_pkg::SYNC0;
    pkt[1] = spd_pkg::SYNC1;
    pkt[2] = ver;
    for (int i = 3; i < NBYTES - 2; i++) begin
      pkt[i] = extremes ? (all_ones ? 8'hFF : 8'h00) : 8'($urandom);
    end
    if (extremes && all_ones) begin
      // Most negative motion values on the left, most positive on the right.
      pkt[19] = 8'h00; pkt[20] = 8'h80; pkt[21] = 8'h00; pkt[22] = 8'h80;
      pkt[25] = 8'hFF; pkt[26] = 8'h7F; pkt[27] = 8'hFF; pkt[28] = 8'h7F;
    end
    c = crc16_ccitt(pkt, NBYTES - 2);
    if (bad_crc) c = c ^ (16'd1 << $urandom_range(0, 15));
    pkt[NBYTES - 2] = c[7:0];
    pkt[NBYTES - 1] = c[15:8];
    for (int i = 0; i < NBYTES; i++) push_byte(pkt[i]);
  endtask

  // Hold until every expected result is back, then allow for the slowest latency.
  task automatic wait_drained();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    version_reg = v;
  endtask

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    spd_pkg::result_t exp_r;
    spd_pkg::result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (expected_results.size() == 0) begin
        $error("result with no expectation: outcome %0d", got.outcome);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.outcome !== exp_r.outcome) begin
          $error("outcome exp %0d got %0d", exp_r.outcome, got.outcome); error_count++;
        end
        if (got.pkt_counter !== exp_r.pkt_counter) begin
          $error("pkt_counter exp %h got %h", exp_r.pkt_counter, got.pkt_counter);
          error_count++;
        end
        if (got.stamp_usec !== exp_r.stamp_usec) begin
          $error("stamp_usec exp %h got %h", exp_r.stamp_usec, got.stamp_usec);
          error_count++;
        end
        if (got.interval_us !== exp_r.interval_us) begin
          $error("interval_us exp %h got %h", exp_r.interval_us, got.interval_us);
          error_count++;
        end
        if (got.left_dx !== exp_r.left_dx) begin
          $error("left_dx exp %h got %h", exp_r.left_dx, got.left_dx); error_count++;
        end
        if (got.left_dy !== exp_r.left_dy) begin
          $error("left_dy exp %h got %h", exp_r.left_dy, got.left_dy); error_count++;
        end
        if (got.left_quality !== exp_r.left_quality) begin
          $error("left_quality exp %h got %h", exp_r.left_quality, got.left_quality);
          error_count++;
        end
        if (got.left_status !== exp_r.left_status) begin
          $error("left_status exp %h got %h", exp_r.left_status, got.left_status);
          error_count++;
        end
        if (got.right_dx !== exp_r.right_dx) begin
          $error("right_dx exp %h got %h", exp_r.right_dx, got.right_dx); error_count++;
        end
        if (got.right_dy !== exp_r.right_dy) begin
          $error("right_dy exp %h got %h", exp_r.right_dy, got.right_dy); error_count++;
        end
        if (got.right_quality !== exp_r.right_quality) begin
          $error("right_quality exp %h got %h", exp_r.right_quality, got.right_quality);
          error_count++;
        end
        if (got.right_status !== exp_r.right_status) begin
          $error("right_status exp %h got %h", exp_r.right_status, got.right_status);
          error_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
        long_hold = 1'b0;
      end else if (snk_idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Extremes of the version register, a valid packet, each error outcome, clear.
  task automatic test_directed();
    write_version(8'h00);
    send_packet(8'h00, 1'b0, 1'b1, 1'b0);
    send_packet(8'h00, 1'b0, 1'b1, 1'b1);
    write_version(8'hFF);
    send_packet(8'hFF, 1'b0, 1'b0, 1'b0);
    send_packet(8'hFE, 1'b0, 1'b0, 1'b0);
    send_packet(8'hFF, 1'b1, 1'b0, 1'b0);
    // Drop a full window with a clear, then a clear on an empty window.
    for (int i = 0; i < 20; i++) push_byte(8'($urandom));
    send_byte(spd_pkg::OP_CLEAR, 8'hFF);
    send_byte(spd_pkg::OP_CLEAR, 8'h00);
    // Header split by a clear must not decode.
    push_byte(spd_pkg::SYNC0);
    push_byte(spd_pkg::SYNC1);
    send_byte(spd_pkg::OP_CLEAR, 8'h5A);
    write_version(spd_pkg::VERSION_RESET);
  endtask

  // Long receiver hold-off while the sender keeps offering bytes.
  task automatic test_backpressure();
    long_hold = 1'b1;
    send_packet(version_reg, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 10; i++) push_byte(8'($urandom));
    // Pause the sender until every expected result is back.
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Random mix: mostly well-formed packets, plus noise, bad packets and clears.
  task automatic test_random(input int n_items, input logic [7:0] ver);
    int sent;
    int pick;
    sent = 0;
    write_version(ver);
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_packet(ver, 1'b0, 1'b0, 1'b0);
        sent += NBYTES;
      end else if (pick == 5) begin
        send_packet(ver, 1'b1, 1'b0, 1'b0);
        sent += NBYTES;
      end else if (pick == 6) begin
        send_packet(8'(ver + $urandom_range(1, 255)), 1'b0, 1'b0, 1'b0);
        sent += NBYTES;
      end else if (pick == 7) begin
        send_byte(spd_pkg::OP_CLEAR, 8'($urandom));
        sent++;
      end else begin
        repeat ($urandom_range(1, 5)) begin
          push_byte(($urandom_range(0, 3) == 0) ? spd_pkg::SYNC0 : 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    error_count = 0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    long_hold = 1'b0;
    fill_level = 0;
    skip_left = 0;
    version_reg = spd_pkg::VERSION_RESET;
    for (int i = 0; i < NBYTES; i++) win_bytes[i] = '0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = spd_pkg::OP_PUSH;
    in_ch.data_byte = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random(200, 8'($urandom));
    test_random(150, 8'h01);
    // Last part: no idling on either side.
    wait_drained();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random(150, 8'hFF);

    wait_drained();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

[files.f]
rtl/core/spd_pkg.sv
rtl/core/spd_if.sv
rtl/core/spd_ram.sv
rtl/core/spd_judge.sv
rtl/core/sensor_packet_deframer_crc16_top.sv
bench/sensor_packet_deframer_crc16_top_test.sv
